// File: design/pidir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pidir_pkg
// Shared types and constants for the PID controller with integral reset.
// ---------------------------------------------------------------------------
package pidir_pkg;

    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int INTEG_W = 32;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DB_W    = 15;
    localparam int DRIVE_W = 32;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_GAIN_P      = 3'd0;
    localparam logic [2:0] REG_GAIN_I      = 3'd1;
    localparam logic [2:0] REG_GAIN_D      = 3'd2;
    localparam logic [2:0] REG_INTEG_UPPER = 3'd3;
    localparam logic [2:0] REG_INTEG_LOWER = 3'd4;
    localparam logic [2:0] REG_DEADBAND    = 3'd5;

    localparam logic [INTEG_W-1:0] INTEG_UPPER_RST = 32'h7FFF_FFFF;
    localparam logic [INTEG_W-1:0] INTEG_LOWER_RST = 32'h8000_0000;
    localparam logic [DB_W-1:0]    DEADBAND_RST    = 15'd3;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [INTEG_W-1:0] integral_upper;
        logic signed [INTEG_W-1:0] integral_lower;
        logic [DB_W-1:0]           deadband;
    } cfg_t;

    // payload handed from the integrator stage to the drive stage
    typedef struct packed {
        logic                      clear;
        logic                      cleared;
        logic signed [ERR_W-1:0]   err;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DIFF_W-1:0]  diff;
    } stage_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               saturated;
        logic               integral_cleared;
    } result_t;

endpackage
`default_nettype wire

// File: design/pid_with_integral_reset.sv
`timescale 1ns / 1ps
`default_nettype none
// Stages: the integrator stage register, then the drive stage into the output
// register. Throughput: one transaction per cycle unless out_stall holds the
// output; the integrator state update is a single 33-bit add and compare, so
// it closes within the accepting cycle.
// Reset: rst_n asynchronous, active low; clears integral, last error, valid
// flags and loads the register defaults.
// ---------------------------------------------------------------------------
// pid_with_integral_reset
// Fixed-point PID controller with deadband and window reset of the integral.
// ---------------------------------------------------------------------------
module pid_with_integral_reset (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               func,
    input  wire logic signed [pidir_pkg::ERR_W-1:0] error_in,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [pidir_pkg::DRIVE_W-1:0]    drive,
    output logic                                    saturated,
    output logic                                    integral_cleared,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pidir_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [pidir_pkg::DATA_W-1:0]       pwdata,
    output logic      [pidir_pkg::DATA_W-1:0]       prdata,
    output logic                                    pready
);

    pidir_pkg::cfg_t    cfg;
    pidir_pkg::stage_t  stage;
    pidir_pkg::result_t result;
    pidir_pkg::result_t res_reg;
    pidir_pkg::result_t res_next;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_ready;
    logic s1_ready;
    logic accept;

    // Each stage advances when the stage after it can take its contents; while a
    // finished result waits on out_stall, input is taken only if stage 1 is empty.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;
    assign accept    = in_valid && s1_ready;

    pidir_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Integrator stage: state update happens at the accepting edge, so the next
    // transaction sees the new integral and last error immediately.
    pidir_integ u_integ (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .func     (func),
        .error_in (error_in),
        .cfg      (cfg),
        .stage    (stage)
    );

    pidir_drive u_drive (
        .stage  (stage),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        // hold stage 1 unless it drains into the output register
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        // advance the output register whenever it is free or being taken
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
        res_next       = (out_ready && s1_valid_reg) ? result : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid        = out_valid_reg;
    assign drive            = res_reg.drive;
    assign saturated        = res_reg.saturated;
    assign integral_cleared = res_reg.integral_cleared;

endmodule
`default_nettype wire

// File: design/pidir_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pidir_cfg
// APB-style register file holding gains, integral window and deadband.
// ---------------------------------------------------------------------------
module pidir_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pidir_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pidir_pkg::DATA_W-1:0] pwdata,
    output logic      [pidir_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    output pidir_pkg::cfg_t                   cfg
);

    pidir_pkg::cfg_t cfg_reg;
    pidir_pkg::cfg_t cfg_next;
    logic [2:0]      idx;
    logic            wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                pidir_pkg::REG_GAIN_P:      cfg_next.gain_p = pwdata[15:0];
                pidir_pkg::REG_GAIN_I:      cfg_next.gain_i = pwdata[15:0];
                pidir_pkg::REG_GAIN_D:      cfg_next.gain_d = pwdata[15:0];
                pidir_pkg::REG_INTEG_UPPER: cfg_next.integral_upper = pwdata;
                pidir_pkg::REG_INTEG_LOWER: cfg_next.integral_lower = pwdata;
                pidir_pkg::REG_DEADBAND:    cfg_next.deadband = pwdata[14:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pidir_pkg::REG_GAIN_P:      prdata = 32'($signed(cfg_reg.gain_p));
            pidir_pkg::REG_GAIN_I:      prdata = 32'($signed(cfg_reg.gain_i));
            pidir_pkg::REG_GAIN_D:      prdata = 32'($signed(cfg_reg.gain_d));
            pidir_pkg::REG_INTEG_UPPER: prdata = cfg_reg.integral_upper;
            pidir_pkg::REG_INTEG_LOWER: prdata = cfg_reg.integral_lower;
            pidir_pkg::REG_DEADBAND:    prdata = {17'd0, cfg_reg.deadband};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_upper <= pidir_pkg::INTEG_UPPER_RST;
            cfg_reg.integral_lower <= pidir_pkg::INTEG_LOWER_RST;
            cfg_reg.deadband       <= pidir_pkg::DEADBAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// File: design/pidir_integ.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pidir_integ
// Integrator stage: accumulate error, apply deadband and window reset,
// form the error difference and register the stage payload.
// ---------------------------------------------------------------------------
module pidir_integ (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire logic                               func,
    input  wire logic signed [pidir_pkg::ERR_W-1:0] error_in,
    input  wire pidir_pkg::cfg_t                    cfg,
    output pidir_pkg::stage_t                       stage
);

    logic signed [pidir_pkg::INTEG_W-1:0] integ_reg;
    logic signed [pidir_pkg::INTEG_W-1:0] integ_next;
    logic signed [pidir_pkg::ERR_W-1:0]   last_reg;
    logic signed [pidir_pkg::ERR_W-1:0]   last_next;
    pidir_pkg::stage_t                    stage_reg;
    pidir_pkg::stage_t                    stage_next;

    logic signed [pidir_pkg::INTEG_W:0]   sum_wide;
    logic signed [pidir_pkg::DIFF_W-1:0]  err_ext;
    logic        [pidir_pkg::DIFF_W-1:0]  mag;
    logic                                 clr_db;
    logic                                 clr_win;

    assign err_ext  = pidir_pkg::DIFF_W'(error_in);
    assign sum_wide = 33'(integ_reg) + 33'(error_in);
    assign mag      = error_in[15] ? 17'(-err_ext) : 17'(err_ext);
    assign clr_db   = mag < {2'b00, cfg.deadband};
    assign clr_win  = (sum_wide > 33'(cfg.integral_upper))
                   || (sum_wide < 33'(cfg.integral_lower));

    always_comb
    begin
        integ_next = integ_reg;
        last_next  = last_reg;
        stage_next = stage_reg;
        if (load)
        begin
            if (func)
            begin
                // clear transaction: drop both state words
                integ_next         = '0;
                last_next          = '0;
                stage_next.clear   = 1'b1;
                stage_next.cleared = 1'b1;
                stage_next.err     = '0;
                stage_next.integ   = '0;
                stage_next.diff    = '0;
            end
            else
            begin
                integ_next         = (clr_db || clr_win) ? '0 : sum_wide[31:0];
                last_next          = error_in;
                stage_next.clear   = 1'b0;
                stage_next.cleared = clr_db || clr_win;
                stage_next.err     = error_in;
                stage_next.integ   = (clr_db || clr_win) ? '0 : sum_wide[31:0];
                stage_next.diff    = err_ext - pidir_pkg::DIFF_W'(last_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            integ_reg <= integ_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage = stage_reg;

endmodule
`default_nettype wire

// File: design/pidir_drive.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pidir_drive
// Drive computation: three gain products, sum, floor shift by 8, saturate.
// ---------------------------------------------------------------------------
module pidir_drive (
    input  wire pidir_pkg::stage_t stage,
    input  wire pidir_pkg::cfg_t   cfg,
    output pidir_pkg::result_t     result
);

    logic signed [31:0] prod_p;
    logic signed [47:0] prod_i;
    logic signed [32:0] prod_d;
    logic signed [49:0] total;
    logic signed [41:0] q;
    logic               sat_hi;
    logic               sat_lo;

    assign prod_p = 32'($signed(cfg.gain_p)) * 32'($signed(stage.err));
    assign prod_i = 48'($signed(cfg.gain_i)) * 48'($signed(stage.integ));
    assign prod_d = 33'($signed(cfg.gain_d)) * 33'($signed(stage.diff));
    assign total  = 50'(prod_p) + 50'(prod_i) + 50'(prod_d);

    // arithmetic shift right by 8 rounds toward minus infinity
    assign q      = total[49:8];
    assign sat_hi = !q[41] && (q[40:31] != '0);
    assign sat_lo = q[41] && (q[40:31] != '1);

    always_comb
    begin
        result.integral_cleared = stage.cleared;
        if (stage.clear)
        begin
            result.drive     = '0;
            result.saturated = 1'b0;
        end
        else if (sat_hi)
        begin
            result.drive     = 32'h7FFF_FFFF;
            result.saturated = 1'b1;
        end
        else if (sat_lo)
        begin
            result.drive     = 32'h8000_0000;
            result.saturated = 1'b1;
        end
        else
        begin
            result.drive     = q[31:0];
            result.saturated = 1'b0;
        end
    end

endmodule
`default_nettype wire

// File: tb/pid_with_integral_reset_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pid_with_integral_reset_tb
// Self-checking bench for the fixed-point PID controller with integral reset.
// A queue-fed driver offers error samples and clear requests, a predictor
// computes each expected drive as the sample is taken, and a monitor compares
// every returned drive, saturation flag and integral-cleared flag in order.
// ---------------------------------------------------------------------------
module pid_with_integral_reset_tb;

    // item operations on the func input
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam int     IDLE_PCT        = 35;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     SETTLE_CYCLES   = 4;     // pipeline is two deep
    localparam int     WATCHDOG_LIMIT  = 2000;
    localparam int     PRINT_CAP       = 40;
    localparam longint DRIVE_MAX       = 64'sd2147483647;
    localparam longint DRIVE_MIN       = -64'sd2147483648;
    localparam int     RAMP_ITEMS      = 520;   // from the 512th sample of -32768 on the drive clips
    localparam int     RAMP_TAIL_ITEMS = 20;

    typedef struct packed {
        logic                               op;
        logic signed [pidir_pkg::ERR_W-1:0] err;
    } pid_item_t;

    // DUT connections, all inputs known from time zero
    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 in_valid  = 1'b0;
    logic                                 in_stall;
    logic                                 func      = FUNC_UPDATE;
    logic signed [pidir_pkg::ERR_W-1:0]   error_in  = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [pidir_pkg::DRIVE_W-1:0] drive;
    logic                                 saturated;
    logic                                 integral_cleared;
    logic                                 psel      = 1'b0;
    logic                                 penable   = 1'b0;
    logic                                 pwrite    = 1'b0;
    logic [pidir_pkg::ADDR_W-1:0]         paddr     = '0;
    logic [pidir_pkg::DATA_W-1:0]         pwdata    = '0;
    logic [pidir_pkg::DATA_W-1:0]         prdata;
    logic                                 pready;

    // stimulus and expectation stores
    pid_item_t          pending_q[$];
    pidir_pkg::result_t drive_expect_q[$];
    int                 mismatch_count = 0;

    // run control, written by the sequencer on falling edges only
    bit calm     = 1'b0;
    int hold_req = 0;

    // register mirror
    logic signed [pidir_pkg::GAIN_W-1:0]  mir_gain_p = '0;
    logic signed [pidir_pkg::GAIN_W-1:0]  mir_gain_i = '0;
    logic signed [pidir_pkg::GAIN_W-1:0]  mir_gain_d = '0;
    logic signed [pidir_pkg::INTEG_W-1:0] mir_win_hi = pidir_pkg::INTEG_UPPER_RST;
    logic signed [pidir_pkg::INTEG_W-1:0] mir_win_lo = pidir_pkg::INTEG_LOWER_RST;
    logic [pidir_pkg::DB_W-1:0]           mir_dead   = pidir_pkg::DEADBAND_RST;

    // controller state mirror
    longint                             integ_acc = 0;
    logic signed [pidir_pkg::ERR_W-1:0] prev_err  = '0;

    pid_with_integral_reset u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .error_in         (error_in),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .drive            (drive),
        .saturated        (saturated),
        .integral_cleared (integral_cleared),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // Advance the controller mirror by one transaction and return its result.
    function automatic pidir_pkg::result_t pid_predict(
        input logic                               op,
        input logic signed [pidir_pkg::ERR_W-1:0] err
    );
        pidir_pkg::result_t r;
        longint             e;
        longint             acc;
        longint             mag;
        longint             total;
        longint             q;
        r = '0;
        if (op == FUNC_CLEAR)
        begin
            integ_acc = 0;
            prev_err  = '0;
            r.integral_cleared = 1'b1;
            return r;
        end
        e   = err;
        acc = integ_acc + e;
        mag = (e < 0) ? -e : e;
        // deadband test looks at the sample, window test at the new sum; either one zeroes it
        if (mag < longint'(mir_dead))
        begin
            acc = 0;
            r.integral_cleared = 1'b1;
        end
        if (acc > longint'(mir_win_hi) || acc < longint'(mir_win_lo))
        begin
            acc = 0;
            r.integral_cleared = 1'b1;
        end
        total = longint'(mir_gain_p) * e + longint'(mir_gain_i) * acc
              + longint'(mir_gain_d) * (e - longint'(prev_err));
        integ_acc = acc;
        prev_err  = err;
        // arithmetic shift rounds toward minus infinity
        q = total >>> 8;
        if (q > DRIVE_MAX)
        begin
            q = DRIVE_MAX;
            r.saturated = 1'b1;
        end
        else if (q < DRIVE_MIN)
        begin
            q = DRIVE_MIN;
            r.saturated = 1'b1;
        end
        r.drive = q[31:0];
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Input driver: take the next pending item when the slot is free, idling at random unless calm.
    // Predict at the edge that accepts the transaction, so the mirror sees
    // items in exactly the order the block does.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : input_driver
        pid_item_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                drive_expect_q.push_back(pid_predict(func, error_in));
            // hold a stalled transaction untouched; otherwise offer or idle
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_q.pop_front();
                    in_valid <= 1'b1;
                    func     <= nxt.op;
                    error_in <= nxt.err;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Output stall: random back-pressure, or a long hold-off on request so the
    // pipeline fills and pushes back on the input side.
    // -----------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // -----------------------------------------------------------------------
    // Result monitor: compare each accepted transaction with the oldest
    // expectation, field by field.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        pidir_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expect_q.size() == 0)
                report_mismatch("result with nothing outstanding, drive", drive, 0);
            else
            begin
                want = drive_expect_q.pop_front();
                if (drive !== want.drive)
                    report_mismatch("drive", drive, longint'(signed'(want.drive)));
                if (saturated !== want.saturated)
                    report_mismatch("saturated", saturated, want.saturated);
                if (integral_cleared !== want.integral_cleared)
                    report_mismatch("integral_cleared", integral_cleared,
                                    want.integral_cleared);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: drop the run if no transaction moves for too long.
    // -----------------------------------------------------------------------
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("pid_with_integral_reset_tb: errors");
            $finish;
        end
    end

    // ---- sequencer helpers ------------------------------------------------

    // One APB write: setup cycle, access cycle, done on the pready edge.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // the block keeps only the low bits of the gain and deadband registers
        case (idx)
            pidir_pkg::REG_GAIN_P:      mir_gain_p = val[pidir_pkg::GAIN_W-1:0];
            pidir_pkg::REG_GAIN_I:      mir_gain_i = val[pidir_pkg::GAIN_W-1:0];
            pidir_pkg::REG_GAIN_D:      mir_gain_d = val[pidir_pkg::GAIN_W-1:0];
            pidir_pkg::REG_INTEG_UPPER: mir_win_hi = val;
            pidir_pkg::REG_INTEG_LOWER: mir_win_lo = val;
            pidir_pkg::REG_DEADBAND:    mir_dead   = val[pidir_pkg::DB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_cfg(input logic [31:0] gp, input logic [31:0] gi, input logic [31:0] gd,
                            input logic [31:0] hi, input logic [31:0] lo, input logic [31:0] db);
        cfg_write(pidir_pkg::REG_GAIN_P, gp);
        cfg_write(pidir_pkg::REG_GAIN_I, gi);
        cfg_write(pidir_pkg::REG_GAIN_D, gd);
        cfg_write(pidir_pkg::REG_INTEG_UPPER, hi);
        cfg_write(pidir_pkg::REG_INTEG_LOWER, lo);
        cfg_write(pidir_pkg::REG_DEADBAND, db);
        @(negedge clk);
    endtask

    task automatic rand_cfg();
        int          w;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] g[3];
        logic [31:0] db;
        w = $urandom_range(1, 1 << 20);
        case ($urandom_range(3))
            0:       begin hi = 32'h7FFF_FFFF; lo = 32'h8000_0000; end
            1:       begin hi = w;             lo = -w;            end
            2:       begin hi = -w;            lo = w;             end  // empty window
            default: begin hi = $urandom();    lo = $urandom();    end
        endcase
        // mix full-range words (upper bits must be dropped) with modest gains
        foreach (g[k])
            g[k] = $urandom_range(1) ? $urandom() : ($urandom_range(2047) - 1024);
        db = $urandom_range(1) ? $urandom_range(24) : $urandom();
        load_cfg(g[0], g[1], g[2], hi, lo, db);
    endtask

    task automatic push_item(input logic op, input int v);
        pid_item_t it;
        it.op  = op;
        it.err = v[pidir_pkg::ERR_W-1:0];
        pending_q.push_back(it);
    endtask

    // Random traffic: mostly same-sign runs that build up the integral,
    // with deadband-edge samples, extremes, clears and plain noise mixed in.
    task automatic fill_random(input int n);
        int count;
        int pick;
        int run_len;
        int base;
        int v;
        count = 0;
        while (count < n)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                push_item(FUNC_CLEAR, $urandom());
                count++;
            end
            else if (pick < 50)
            begin
                run_len = $urandom_range(2, 40);
                base = $urandom_range(1) ? $urandom_range(600) : $urandom_range(32767);
                if ($urandom_range(1))
                    base = -base;
                for (int k = 0; k < run_len && count < n; k++)
                begin
                    v = base + $urandom_range(16) - 8;
                    if (v > 32767)
                        v = 32767;
                    if (v < -32768)
                        v = -32768;
                    push_item(FUNC_UPDATE, v);
                    count++;
                end
            end
            else if (pick < 65)
            begin
                v = int'(mir_dead) + $urandom_range(4) - 2;
                push_item(FUNC_UPDATE, $urandom_range(1) ? v : -v);
                count++;
            end
            else if (pick < 75)
            begin
                case ($urandom_range(4))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 1;
                    3:       v = -1;
                    default: v = 0;
                endcase
                push_item(FUNC_UPDATE, v);
                count++;
            end
            else
            begin
                push_item(FUNC_UPDATE, $urandom());
                count++;
            end
        end
    endtask

    // Wait for every offered item to be taken and every result to return,
    // then let the pipeline settle before touching registers.
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || drive_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---- sequencer ----------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: zero gains, full window, small deadband
        push_item(FUNC_UPDATE, 0);
        push_item(FUNC_CLEAR, 16'h5A5A);
        drain();

        // unit P gain, half I gain, quarter D gain, window of +/-1024, deadband of 3
        load_cfg(32'h0100, 32'h0080, 32'h0040, 1024, -1024, 3);
        // deadband edges: below 3 clears, 3 and -3 keep the integral
        push_item(FUNC_UPDATE, 0);
        push_item(FUNC_UPDATE, 1);
        push_item(FUNC_UPDATE, -1);
        push_item(FUNC_UPDATE, 2);
        push_item(FUNC_UPDATE, -2);
        push_item(FUNC_UPDATE, 3);
        push_item(FUNC_UPDATE, -3);
        push_item(FUNC_CLEAR, 0);
        // land exactly on the upper limit, then step past it
        repeat (4) push_item(FUNC_UPDATE, 256);
        push_item(FUNC_UPDATE, 3);
        push_item(FUNC_CLEAR, -1);
        // same on the lower limit
        repeat (4) push_item(FUNC_UPDATE, -256);
        push_item(FUNC_UPDATE, -3);
        push_item(FUNC_UPDATE, 32767);
        push_item(FUNC_UPDATE, -32768);
        drain();

        // extreme gains and the widest deadband, then random traffic on it
        load_cfg(32'h7FFF, 32'h8000, 32'h8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF);
        push_item(FUNC_UPDATE, 32767);
        push_item(FUNC_UPDATE, -32768);
        push_item(FUNC_UPDATE, 32766);
        fill_random(180);
        drain();

        // ramp with no idling: build a large negative integral with the widest
        // window so the drive clips high, then flip the integral gain and keep
        // going so it clips low
        calm <= 1'b1;
        load_cfg(32'h0000, 32'h8000, 32'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        repeat (RAMP_ITEMS) push_item(FUNC_UPDATE, -32768);
        drain();
        load_cfg(32'h0000, 32'h7FFF, 32'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        repeat (RAMP_TAIL_ITEMS) push_item(FUNC_UPDATE, -32768);
        drain();
        calm <= 1'b0;

        // random phases, each under its own register setting
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       load_cfg(32'h8000, 32'h8000, 32'h8000, -1, 1, 0);  // empty window
                1:       load_cfg(32'h0100, 32'h7FFF, 32'h0100, 0, 0, 0);   // window of one point
                default: rand_cfg();
            endcase
            if (p == 3)
                calm <= 1'b1;
            if (p == 4)
            begin
                // pause the sender mid-phase until everything has come back
                fill_random(50);
                drain();
                fill_random(50);
            end
            else
                fill_random(100);
            if (p == 2)
            begin
                // let a few transactions start, then block the output for a while
                repeat (5) @(negedge clk);
                hold_req = hold_req + 1;
            end
            drain();
            calm <= 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (drive_expect_q.size() != 0)
            report_mismatch("results still outstanding", drive_expect_q.size(), 0);
        if (mismatch_count == 0)
            $display("pid_with_integral_reset_tb: clean");
        else
            $display("pid_with_integral_reset_tb: errors");
        $finish;
    end

endmodule
